/* sv/b32e_pkg.sv */
// ----------------------------------------------------------------------------
// b32e_pkg
// Shared types and constants for the LSB-first base32 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b32e_pkg;

	localparam int unsigned GROUP_BITS = 5;
	localparam int unsigned BYTE_BITS  = 8;
	localparam int unsigned STORE_BITS = 12;
	localparam int unsigned COUNT_BITS = 4;
	localparam int unsigned TOTAL_BITS = 16;
	localparam int unsigned CODE_BITS  = 7;

	// hard cap on characters per message, applied on top of the register
	localparam logic [31:0] MAX_OUTPUT_LEN = 32'd65535;
	localparam logic [TOTAL_BITS-1:0] LIMIT_RESET = 16'hFFFF;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_LIMIT = 1'b1;

	// 0-9 then bcdfghjklmnpqrstuvwxyz
	localparam logic [CODE_BITS-1:0] ALPHABET [0:31] = '{
		7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
		7'h38, 7'h39, 7'h62, 7'h63, 7'h64, 7'h66, 7'h67, 7'h68,
		7'h6A, 7'h6B, 7'h6C, 7'h6D, 7'h6E, 7'h70, 7'h71, 7'h72,
		7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7A
	};

	typedef struct packed {
		logic [CODE_BITS-1:0]  char_code;
		logic                  status;
		logic [TOTAL_BITS-1:0] char_total;
		logic                  final_flag;
	} result_t;

	// what the core does in the current cycle
	typedef struct packed {
		logic    adv;     // core commits a step this cycle
		logic    emit;    // the step produces a result
		logic    retire;  // the step finishes the held item
		result_t res;
	} step_t;

endpackage : b32e_pkg

`default_nettype wire

/* sv/b32e_core.sv */
// ----------------------------------------------------------------------------
// b32e_core
// Message state and per-cycle character generation: at most one result per step.
// ----------------------------------------------------------------------------
`default_nettype none

module b32e_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               item_valid,
	input  wire logic [b32e_pkg::BYTE_BITS-1:0]     data_byte,
	input  wire logic                               msg_end,
	input  wire logic                               out_free,
	input  wire logic [b32e_pkg::TOTAL_BITS-1:0]    limit,
	output b32e_pkg::step_t                         step
);

	logic [b32e_pkg::STORE_BITS-1:0] acc_q;
	logic [b32e_pkg::COUNT_BITS-1:0] cnt_q;
	logic [b32e_pkg::TOTAL_BITS-1:0] emit_q;
	logic                            ovf_q;
	logic                            merged_q;  // held byte already in acc_q

	logic [b32e_pkg::STORE_BITS-1:0] acc_v;
	logic [b32e_pkg::COUNT_BITS-1:0] cnt_v;
	logic [b32e_pkg::COUNT_BITS-1:0] rem;
	logic [b32e_pkg::TOTAL_BITS-1:0] emit_inc;
	logic skip, grp, flush, due, lim_hit, final_ok, retire, clear, set_ovf, adv;

	always_comb begin
		if (merged_q) begin
			acc_v = acc_q;
			cnt_v = cnt_q;
		end else begin
			acc_v = acc_q | ({4'd0, data_byte} << cnt_q[2:0]);
			cnt_v = cnt_q + 4'(b32e_pkg::BYTE_BITS);
		end
	end

	assign skip     = !merged_q && ovf_q;
	assign grp      = cnt_v >= 4'(b32e_pkg::GROUP_BITS);
	assign flush    = !grp && msg_end && (cnt_v != 4'd0);
	assign due      = !skip && (grp || flush);
	assign lim_hit  = emit_q >= limit;
	assign rem      = cnt_v - 4'(b32e_pkg::GROUP_BITS);
	assign emit_inc = emit_q + 16'd1;
	assign final_ok = flush || (grp && msg_end && rem == 4'd0);

	always_comb begin
		if (due)
			retire = lim_hit || final_ok ||
				(!msg_end && rem < 4'(b32e_pkg::GROUP_BITS));
		else
			retire = 1'b1;
	end

	assign clear   = (skip && msg_end) ||
		(due && ((final_ok && !lim_hit) || (lim_hit && msg_end)));
	assign set_ovf = due && lim_hit && !msg_end;
	assign adv     = item_valid && (!due || out_free);

	always_comb begin
		step.adv    = adv;
		step.emit   = adv && due;
		step.retire = retire;
		if (lim_hit) begin
			step.res.char_code  = '0;
			step.res.status     = b32e_pkg::STATUS_LIMIT;
			step.res.char_total = emit_q;
			step.res.final_flag = 1'b1;
		end else begin
			step.res.char_code  = b32e_pkg::ALPHABET[acc_v[4:0]];
			step.res.status     = b32e_pkg::STATUS_OK;
			step.res.char_total = final_ok ? emit_inc : '0;
			step.res.final_flag = final_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			cnt_q    <= '0;
			emit_q   <= '0;
			ovf_q    <= 1'b0;
			merged_q <= 1'b0;
		end else if (adv) begin
			if (clear) begin
				acc_q    <= '0;
				cnt_q    <= '0;
				emit_q   <= '0;
				ovf_q    <= 1'b0;
				merged_q <= 1'b0;
			end else if (set_ovf) begin
				ovf_q    <= 1'b1;
				merged_q <= 1'b0;
			end else if (due) begin
				acc_q    <= acc_v >> b32e_pkg::GROUP_BITS;
				cnt_q    <= rem;
				emit_q   <= emit_inc;
				merged_q <= !retire;
			end else if (!skip) begin
				acc_q    <= acc_v;
				cnt_q    <= cnt_v;
				merged_q <= 1'b0;
			end
		end
	end

	// between items of a live message at most four bits wait
	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(!merged_q && !ovf_q) |-> cnt_q < 4'(b32e_pkg::GROUP_BITS))
		else $error("bit count too large between items");

	a_ovf_clean: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> !merged_q)
		else $error("dropped message still holds a merged byte");

	a_ovf_set: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && due && lim_hit && !msg_end) |=> ovf_q)
		else $error("limit hit mid-message did not mark overflow");

endmodule : b32e_core

`default_nettype wire

/* sv/base32_lsb_first_encoder.sv */
// ----------------------------------------------------------------------------
// base32_lsb_first_encoder
// Packs message bytes LSB first into 5-bit groups and emits base32 characters.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry data_byte and msg_end, one byte per
// item. Output channel: out_valid / out_stall carry one character per item,
// with status, char_total and final_flag on the last item of a message.
// Config: cfg_valid / cfg_ready write out_limit (cfg_ready is always high);
// write only while no message byte is in flight.
// The first character of a byte passes the input register and then the output
// register. A byte yields zero, one, two or (at message end) three items,
// one per cycle from the output register while out_stall is low, so a byte
// holds the input register until its last character is produced. Bytes after
// an overflow are dropped and produce no items.
// Out_stall holds the output register; the held byte then waits and in_stall
// rises, so no item is lost.
// Reset clears the message state and sets out_limit to 65535.
// ----------------------------------------------------------------------------
`default_nettype none

module base32_lsb_first_encoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        msg_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [6:0]       char_code,
	output logic             status,
	output logic [15:0]      char_total,
	output logic             final_flag,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	logic [b32e_pkg::TOTAL_BITS-1:0] limit_q;
	logic [b32e_pkg::TOTAL_BITS-1:0] limit;
	logic [31:0]                     limit_ext;

	logic                            item_v_s1;
	logic [b32e_pkg::BYTE_BITS-1:0]  byte_s1;
	logic                            end_s1;

	logic                            out_v_q;
	b32e_pkg::result_t               res_q;

	b32e_pkg::step_t                 step;
	logic                            out_free;
	logic                            in_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= b32e_pkg::LIMIT_RESET;
		else if (cfg_valid && cfg_ready)
			limit_q <= cfg_data;
	end

	assign limit_ext = {16'd0, limit_q};
	assign limit     = (limit_ext > b32e_pkg::MAX_OUTPUT_LEN) ?
		16'(b32e_pkg::MAX_OUTPUT_LEN) : limit_q;

	assign out_free = !out_v_q || !out_stall;
	assign in_stall = item_v_s1 && !(step.adv && step.retire);
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			item_v_s1 <= 1'b0;
		else if (in_take)
			item_v_s1 <= 1'b1;
		else if (step.adv && step.retire)
			item_v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
			end_s1  <= msg_end;
		end
	end

	b32e_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_v_s1),
		.data_byte  (byte_s1),
		.msg_end    (end_s1),
		.out_free   (out_free),
		.limit      (limit),
		.step       (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (step.emit)
			out_v_q <= 1'b1;
		else if (!out_stall)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step.emit)
			res_q <= step.res;
	end

	assign out_valid  = out_v_q;
	assign char_code  = res_q.char_code;
	assign status     = res_q.status;
	assign char_total = res_q.char_total;
	assign final_flag = res_q.final_flag;

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == b32e_pkg::STATUS_LIMIT) |->
			(final_flag && char_code == 7'd0))
		else $error("error item not marked last or carries a character");

	a_total_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !final_flag) |-> char_total == 16'd0)
		else $error("character count shown on a non-final item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(res_q)))
		else $error("stalled output item changed");

endmodule : base32_lsb_first_encoder

`default_nettype wire

/* tb/sv/base32_lsb_first_encoder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base32_lsb_first_encoder_tb
// Drives message bytes into the LSB-first base32 encoder and checks every
// character, limit error and message total against an in-bench encoder model.
// ----------------------------------------------------------------------------

module base32_lsb_first_encoder_tb;

	localparam int    CYCLE_LIMIT = 200000;
	localparam int    SETTLE      = 8;
	localparam string DIGITS      = "0123456789bcdfghjklmnpqrstuvwxyz";

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} msg_byte_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        msg_end   = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [6:0]  char_code;
	logic        status;
	logic [15:0] char_total;
	logic        final_flag;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data  = 16'h0000;

	base32_lsb_first_encoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.msg_end    (msg_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.char_code  (char_code),
		.status     (status),
		.char_total (char_total),
		.final_flag (final_flag),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// encoder model state
	logic [11:0] acc_bits    = '0;
	logic [3:0]  acc_len     = '0;
	logic [15:0] chars_sent  = '0;
	logic        acc_dropped = 1'b0;
	logic [15:0] limit_now   = b32e_pkg::LIMIT_RESET;

	msg_byte_t         feed_q [$];
	b32e_pkg::result_t char_q [$];

	bit calm = 1'b0;
	int mismatches = 0;
	int bytes_taken = 0;
	int chars_seen = 0;
	int limit_hits = 0;
	int msgs_closed = 0;
	int limit_writes = 0;
	int cycle_no = 0;

	function automatic void clear_msg();
		acc_bits    = '0;
		acc_len     = '0;
		chars_sent  = '0;
		acc_dropped = 1'b0;
	endfunction

	// one character from the low group, or the limit error; 0 means stopped
	function automatic bit emit_group();
		b32e_pkg::result_t r;
		byte               c;
		if (chars_sent >= limit_now) begin
			r.char_code  = '0;
			r.status     = b32e_pkg::STATUS_LIMIT;
			r.char_total = chars_sent;
			r.final_flag = 1'b1;
			char_q.push_back(r);
			return 1'b0;
		end
		c = DIGITS[acc_bits[4:0]];
		r.char_code  = c[6:0];
		r.status     = b32e_pkg::STATUS_OK;
		r.char_total = '0;
		r.final_flag = 1'b0;
		char_q.push_back(r);
		chars_sent = chars_sent + 16'd1;
		return 1'b1;
	endfunction

	function automatic void encode_byte(input logic [7:0] d, input logic last);
		b32e_pkg::result_t r;
		if (acc_dropped) begin
			if (last)
				clear_msg();
			return;
		end
		acc_bits = acc_bits | (12'(d) << acc_len[2:0]);
		acc_len  = acc_len + 4'd8;
		while (acc_len >= 4'd5) begin
			if (!emit_group()) begin
				if (last)
					clear_msg();
				else
					acc_dropped = 1'b1;
				return;
			end
			acc_len  = acc_len - 4'd5;
			acc_bits = acc_bits >> 5;
		end
		if (last) begin
			// leftover bits flushed as a final character
			if (acc_len != 4'd0 && !emit_group()) begin
				clear_msg();
				return;
			end
			r = char_q.pop_back();
			r.char_total = chars_sent;
			r.final_flag = 1'b1;
			char_q.push_back(r);
			clear_msg();
		end
	endfunction

	function automatic void cmp_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// byte driver
	always @(posedge clk) begin : drive
		msg_byte_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				encode_byte(data_byte, msg_end);
				bytes_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (feed_q.size() != 0 && (calm || $urandom_range(0, 99) >= 22)) begin
					it = feed_q.pop_front();
					data_byte <= it.data;
					msg_end   <= it.last;
					in_valid  <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// character monitor
	always @(posedge clk) begin : watch
		b32e_pkg::result_t w;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (char_q.size() == 0) begin
					$display("%0t: unexpected item, expected none actual code %h st %b tot %0d fin %b",
						$time, char_code, status, char_total, final_flag);
					mismatches++;
				end else begin
					w = char_q.pop_front();
					cmp_field("char_code", 16'(w.char_code), 16'(char_code));
					cmp_field("status", 16'(w.status), 16'(status));
					cmp_field("char_total", w.char_total, char_total);
					cmp_field("final_flag", 16'(w.final_flag), 16'(final_flag));
				end
				chars_seen++;
				if (status == b32e_pkg::STATUS_LIMIT)
					limit_hits++;
				if (final_flag)
					msgs_closed++;
			end
			out_stall <= !calm && ($urandom_range(0, 99) < 22);
		end
	end

	always @(posedge clk) begin
		cycle_no++;
		if (cycle_no > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d items still expected", $time, char_q.size());
			$display("base32_lsb_first_encoder_tb NOT OK");
			$finish;
		end
	end

	function automatic void push_byte(input logic [7:0] d, input logic last);
		msg_byte_t it;
		it.data = d;
		it.last = last;
		feed_q.push_back(it);
	endfunction

	// random message, mostly short, bytes biased towards all-zero and all-one
	function automatic int queue_message();
		int len;
		int k;
		logic [7:0] d;
		len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
		for (k = 0; k < len; k++) begin
			case ($urandom_range(0, 9))
				0:       d = 8'h00;
				1:       d = 8'hFF;
				default: d = 8'($urandom);
			endcase
			push_byte(d, k == len - 1);
		end
		return len;
	endfunction

	task automatic set_limit(input logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_now = v;
		limit_writes++;
		@(negedge clk);
	endtask

	task automatic wait_drain();
		do @(posedge clk); while (feed_q.size() != 0 || in_valid || char_q.size() != 0);
		// bytes after an overflow give nothing, so let the core settle
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin : stimulus
		int n;
		int p;
		int k;
		logic [15:0] lim;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);

		// reset limit: field extremes, exact multiple of five bits, leftovers
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'hA5, 1'b0);
		push_byte(8'h5A, 1'b1);
		push_byte(8'h01, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'hFE, 1'b0);
		push_byte(8'hC3, 1'b1);
		wait_drain();

		// zero limit: error on the final byte, then bytes dropped until the end
		set_limit(16'h0000);
		push_byte(8'h12, 1'b1);
		push_byte(8'h34, 1'b0);
		push_byte(8'h56, 1'b0);
		push_byte(8'h78, 1'b1);
		wait_drain();

		// limit hit by the flushed leftover
		set_limit(16'd1);
		push_byte(8'hFF, 1'b1);
		wait_drain();

		// exactly at the limit
		set_limit(16'd2);
		push_byte(8'h3C, 1'b1);
		push_byte(8'hC3, 1'b1);
		wait_drain();

		set_limit(16'd3);
		push_byte(8'h0F, 1'b0);
		push_byte(8'hF0, 1'b1);
		push_byte(8'h99, 1'b1);
		wait_drain();

		set_limit(16'hFFFF);
		push_byte(8'h55, 1'b0);
		push_byte(8'hAA, 1'b1);
		wait_drain();

		// random phases over several limits, one of them with no idling
		for (p = 0; p < 4; p++) begin
			case (p)
				0:       lim = 16'($urandom_range(0, 15));
				1:       lim = 16'($urandom_range(16, 120));
				2:       lim = 16'($urandom);
				default: lim = 16'hFFFF;
			endcase
			set_limit(lim);
			calm = (p == 2);
			n = 0;
			while (n < 40)
				n += queue_message();
			wait_drain();
		end
		calm = 1'b0;

		// one long message running into a mid-sized limit, then a short one
		set_limit(16'd80);
		for (k = 0; k < 60; k++)
			push_byte(8'($urandom), k == 59);
		push_byte(8'($urandom), 1'b0);
		push_byte(8'($urandom), 1'b1);
		wait_drain();

		$display("covered %0d bytes, %0d output items, %0d messages closed",
			bytes_taken, chars_seen, msgs_closed);
		$display("limit errors %0d, limit writes %0d, mismatches %0d",
			limit_hits, limit_writes, mismatches);
		if (mismatches == 0 && char_q.size() == 0)
			$display("base32_lsb_first_encoder_tb OK");
		else
			$display("base32_lsb_first_encoder_tb NOT OK");
		$finish;
	end

endmodule
